[hw/rtl/psc_pkg.sv]
`timescale 1ns / 1ps
package psc_pkg;

    // Leaf width of the counting tree: cell bits summed per leaf register.
    localparam int unsigned GROUP_W  = 8;
    localparam int unsigned GROUP_CW = 4;

    // What one cell shows its neighbours.
    typedef struct packed {
        logic valid;
        logic pal;
    } psc_link_t;

    // Sideband that travels alongside the count through the tree.
    typedef struct packed {
        logic valid;
        logic counted;
        logic start;
        logic ovf;
    } psc_tag_t;

endpackage

[hw/rtl/psc_cell.sv]
`timescale 1ns / 1ps
module psc_cell
    import psc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       take,
    input  logic       start,
    input  logic [7:0] ch,
    input  logic       prev_valid,
    input  psc_link_t  up_link,
    output psc_link_t  link_out,
    output logic       pal_next
);

    logic       valid_reg;
    logic       valid_next;
    logic       pal_reg;
    logic [7:0] char_reg;
    logic       v_eff;
    logic       match;
    logic       ins;

    // A cell whose upper neighbour is empty is the last stored character, and
    // the text strictly between it and the new character is then empty.
    always_comb begin
        v_eff      = valid_reg & ~start;
        match      = v_eff & (char_reg == ch) & (up_link.pal | ~up_link.valid);
        ins        = ~v_eff & prev_valid;
        pal_next   = match | ins;
        valid_next = v_eff | ins;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            pal_reg <= pal_next;
            if (ins) begin
                char_reg <= ch;
            end
        end
    end

    assign link_out = '{valid: valid_reg, pal: pal_reg};

endmodule

[hw/rtl/psc_count_tree.sv]
`timescale 1ns / 1ps
module psc_count_tree
    import psc_pkg::*;
#(
    parameter int unsigned N_BITS = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [N_BITS-1:0]           bits_in,
    input  psc_tag_t                    tag_in,
    output logic [$clog2(N_BITS+1)-1:0] count_out,
    output psc_tag_t                    tag_out
);

    localparam int unsigned CW     = $clog2(N_BITS + 1);
    localparam int unsigned NG_RAW = (N_BITS + GROUP_W - 1) / GROUP_W;
    localparam int unsigned LG     = $clog2(NG_RAW);
    localparam int unsigned NG     = 1 << LG;

    logic [NG*GROUP_W-1:0] padded;
    logic [GROUP_CW-1:0]   leaf_sum [NG];
    logic [CW-1:0]         node_reg [1:2*NG-1];
    psc_tag_t              tag_reg  [LG+1];

    always_comb begin
        padded              = '0;
        padded[N_BITS-1:0]  = bits_in;
        for (int g = 0; g < NG; g++) begin
            leaf_sum[g] = '0;
            for (int b = 0; b < GROUP_W; b++) begin
                leaf_sum[g] = leaf_sum[g] + GROUP_CW'(padded[g*GROUP_W+b]);
            end
        end
    end

    // Heap-ordered tree: every node is one register level above its children.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int g = 0; g < NG; g++) begin
                node_reg[NG+g] <= CW'(leaf_sum[g]);
            end
            for (int k = 1; k < NG; k++) begin
                node_reg[k] <= node_reg[2*k] + node_reg[2*k+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= LG; j++) begin
                tag_reg[j] <= '0;
            end
        end else if (en) begin
            tag_reg[0] <= tag_in;
            for (int j = 1; j <= LG; j++) begin
                tag_reg[j] <= tag_reg[j-1];
            end
        end
    end

    assign count_out = node_reg[1];
    assign tag_out   = tag_reg[LG];

endmodule

[hw/rtl/palindromic_substring_counter.sv]
`timescale 1ns / 1ps
// Palindromic substring counter.
// Slave channel: one character per beat. s_tdata[7:0] is the byte and
// s_tuser[0] marks the first character of a new string, which clears the
// stored string, the running total and the overflow flag.
// Master channel: one result beat per input beat, in order. It carries the
// number of palindromes ending at that character, the running total for the
// string and a sticky flag set once the string has run past MAX_LEN
// characters; such characters are dropped and report a count of zero.
// A row of MAX_LEN cells holds the characters and one palindrome bit per
// start position; all cells update in the cycle a beat is taken, so a new
// character is accepted every cycle while the receiver does not stall. The
// count is formed by a pipelined adder tree; its leaf and node registers
// are followed by the result register that drives m_tvalid.
// When the receiver stalls, the whole pipeline holds and s_tready falls
// until the result register is drained. Reset empties the cell row, clears
// the total and the overflow flag and leaves no result pending.
module palindromic_substring_counter
    import psc_pkg::*;
#(
    parameter int unsigned MAX_LEN = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic [0:0]  s_tuser,   // [0] start_new
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [8:0] ending_here, [24:9] running_total, zero above
    output logic [0:0]  m_tuser    // [0] length_overflow
);

    localparam int unsigned CW = $clog2(MAX_LEN + 1);
    localparam int unsigned XW = (CW > 9) ? CW : 9;

    logic               en;
    logic               s_accept;
    logic               start;
    logic [7:0]         ch;
    logic               full;
    logic               take;
    logic               ovf_reg;
    logic [MAX_LEN-1:0] valid_vec;
    logic [MAX_LEN-1:0] pal_vec;
    logic [MAX_LEN-1:0] pal_next_vec;
    psc_tag_t           tag_in;
    psc_tag_t           tag_out;
    logic [CW-1:0]      count;

    logic               m_valid_reg;
    logic [8:0]         here_reg;
    logic [8:0]         here_next;
    logic [15:0]        total_reg;
    logic [15:0]        total_next;
    logic               ovf_out_reg;
    logic [XW-1:0]      here_x;
    logic [15:0]        base;
    logic [16:0]        sum;

    assign en       = ~m_valid_reg | m_tready;
    assign s_tready = en;
    assign s_accept = s_tvalid & en;
    assign start    = s_tuser[0];
    assign ch       = s_tdata;
    assign full     = valid_vec[MAX_LEN-1] & ~start;
    assign take     = s_accept & ~full;

    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        logic      prev_valid;
        psc_link_t up_link;
        psc_link_t link_out;

        if (i == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_rest
            assign prev_valid = valid_vec[i-1] & ~start;
        end

        if (i == MAX_LEN - 1) begin : g_top
            assign up_link = '{valid: 1'b0, pal: 1'b0};
        end else begin : g_mid
            assign up_link = '{valid: valid_vec[i+1] & ~start, pal: pal_vec[i+1]};
        end

        psc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .take       (take),
            .start      (start),
            .ch         (ch),
            .prev_valid (prev_valid),
            .up_link    (up_link),
            .link_out   (link_out),
            .pal_next   (pal_next_vec[i])
        );

        assign valid_vec[i] = link_out.valid;
        assign pal_vec[i]   = link_out.pal;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_reg <= 1'b0;
        end else if (s_accept) begin
            ovf_reg <= (ovf_reg & ~start) | full;
        end
    end

    assign tag_in = '{valid: s_accept, counted: ~full, start: start,
                      ovf: (ovf_reg & ~start) | full};

    psc_count_tree #(
        .N_BITS (MAX_LEN)
    ) u_tree (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .bits_in   (pal_next_vec),
        .tag_in    (tag_in),
        .count_out (count),
        .tag_out   (tag_out)
    );

    // The total accumulates the unsaturated count and saturates at its 16-bit
    // field; the reported count is clipped to its 9-bit field.
    always_comb begin
        here_x     = tag_out.counted ? XW'(count) : '0;
        here_next  = (here_x > XW'(511)) ? 9'h1FF : here_x[8:0];
        base       = tag_out.start ? 16'h0000 : total_reg;
        sum        = {1'b0, base} + 17'(here_x);
        total_next = sum[16] ? 16'hFFFF : sum[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            total_reg   <= 16'h0000;
        end else if (en) begin
            m_valid_reg <= tag_out.valid;
            if (tag_out.valid) begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && tag_out.valid) begin
            here_reg    <= here_next;
            ovf_out_reg <= tag_out.ovf;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, total_reg, here_reg};
    assign m_tuser  = ovf_out_reg;

`ifndef SYNTHESIS
    // Occupied cells always form a prefix of the row.
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_vec & ~{valid_vec[MAX_LEN-2:0], 1'b1}) == '0)
        else $error("cell row has a gap");

    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[8:0] == 9'd0)
        else $error("dropped character reported a count");

    a_count_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[8:0] != 9'd0)
        else $error("stored character missed its own palindrome");

    a_total_ge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[24:9] >= {7'b0, m_tdata[8:0]})
        else $error("running total below count");

    a_full_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && full |=> ovf_reg)
        else $error("overflow flag not raised");
`endif

endmodule
